// ----- rtl/cbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cbpf_pkg: shared types and constants of the cutoff bond pair finder
// Widths of the atom store, the distance path and the square root chain.
// ----------------------------------------------------------------------------
package cbpf_pkg;

  // atom store
  localparam int MAX_ATOMS = 64;
  localparam int IDX_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

  // distance path
  localparam int COORD_W = 24;
  localparam int MAG_W   = 24;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int CUT_W   = 21;
  localparam int RAD_W   = 2 * CUT_W;

  // square root chain, one result bit per cell
  localparam int ROOT_W = CUT_W;
  localparam int REM_W  = ROOT_W + 2;

  // configuration
  localparam int                 ADDR_W       = 3;
  localparam int                 DATA_W       = 32;
  localparam logic [0:0]         REG_CUTOFF   = 1'b0;
  localparam logic [CUT_W-1:0]   CUTOFF_RESET = 21'd104858;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } atom_t;

  // control that rides along with every beat of the distance path
  typedef struct packed {
    logic             bond;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } beat_ctl_t;

  typedef struct packed {
    beat_ctl_t         ctl;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_beat_t;

endpackage

// ----- rtl/cutoff_bond_pair_finder.sv -----
// ----------------------------------------------------------------------------
// cutoff_bond_pair_finder: distance cutoff bond search over a ring of atoms
// Each new atom is checked against every stored atom in index order; every
// pair closer than the cutoff gives a bond beat with a floored square root.
//
//  channel  | signals                                   | dir | handshake
//  ---------+-------------------------------------------+-----+------------------
//  atom in  | start_molecule x_coord y_coord z_coord    | in  | start & !busy
//  bond out | earlier_index new_index bond_length       | out | result_valid,
//           | last_bond dropped                         |     | one cycle
//  config   | psel penable pwrite paddr pwdata prdata   | io  | APB, pready = 1
//
// An atom occupies the block for a full scan of all MAX_ATOMS ring cells (one
// ring shift per cycle) and until the distance and square root chain drains.
// A dropped atom (store full) is not stored; its beat appears next cycle.
// Reset empties the store and loads the default cutoff; no clearing pass.
// Bond beats are single cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module cutoff_bond_pair_finder
  import cbpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               start_molecule,
  input  coord_t             x_coord,
  input  coord_t             y_coord,
  input  coord_t             z_coord,
  output logic               result_valid,
  output logic [IDX_W-1:0]   earlier_index,
  output logic [IDX_W-1:0]   new_index,
  output logic [CUT_W-1:0]   bond_length,
  output logic               last_bond,
  output logic               dropped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ATOMS - 1);

  // configuration register
  logic [CUT_W-1:0] bond_cutoff;
  logic [RAD_W-1:0] cutoff_sq;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CUTOFF);
  assign prdata = (paddr[ADDR_W-1] == REG_CUTOFF) ? DATA_W'(bond_cutoff) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bond_cutoff <= CUTOFF_RESET;
    end else if (cfg_wr) begin
      bond_cutoff <= pwdata[CUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cutoff_sq <= bond_cutoff * bond_cutoff;
  end

  // accept and scan control
  logic             accept;
  logic [CNT_W-1:0] cnt_eff;
  logic             full;
  logic             drop_go;
  logic [CNT_W-1:0] atom_count;
  logic             scanning;
  logic             active;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] me;
  atom_t            new_atom;
  atom_t            head;
  sqrt_beat_t       chain [ROOT_W+1];

  assign accept  = start && !busy;
  assign cnt_eff = start_molecule ? '0 : atom_count;
  assign full    = (cnt_eff == CNT_W'(MAX_ATOMS));
  assign drop_go = accept && full;
  assign busy    = scanning || active;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= '0;
      scanning   <= 1'b0;
      active     <= 1'b0;
      step       <= '0;
    end else begin
      if (accept && !full) begin
        atom_count <= cnt_eff + CNT_W'(1);
        scanning   <= 1'b1;
        active     <= 1'b1;
        step       <= '0;
      end else begin
        if (scanning) begin
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            scanning <= 1'b0;
          end
        end
        if (chain[ROOT_W].ctl.fin) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full) begin
      me         <= cnt_eff[IDX_W-1:0];
      new_atom.x <= x_coord;
      new_atom.y <= y_coord;
      new_atom.z <= z_coord;
    end
  end

  cbpf_atom_ring u_ring (
    .clk      (clk),
    .shift    (scanning),
    .insert   (step == me),
    .new_atom (new_atom),
    .head     (head)
  );

  // stage A: absolute coordinate differences
  beat_ctl_t           a_ctl;
  logic [MAG_W-1:0]    ax, ay, az;
  logic signed [COORD_W:0] dx, dy, dz;

  assign dx = {new_atom.x[COORD_W-1], new_atom.x} - {head.x[COORD_W-1], head.x};
  assign dy = {new_atom.y[COORD_W-1], new_atom.y} - {head.y[COORD_W-1], head.y};
  assign dz = {new_atom.z[COORD_W-1], new_atom.z} - {head.z[COORD_W-1], head.z};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else begin
      a_ctl.bond <= scanning && (step < me);
      a_ctl.fin  <= scanning && (step == LAST_STEP);
      a_ctl.idx  <= step;
    end
  end

  always_ff @(posedge clk) begin
    ax <= dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    ay <= dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    az <= dz[COORD_W] ? MAG_W'(-dz) : dz[MAG_W-1:0];
  end

  // stage B: squares
  beat_ctl_t       b_ctl;
  logic [SQ_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else begin
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
  end

  // stage C: sum and cutoff test, feeds the root chain
  logic [SUM_W-1:0] d2;

  assign d2 = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].ctl <= '0;
    end else begin
      chain[0].ctl.bond <= b_ctl.bond && (d2 < SUM_W'(cutoff_sq));
      chain[0].ctl.fin  <= b_ctl.fin;
      chain[0].ctl.idx  <= b_ctl.idx;
    end
    chain[0].rem  <= '0;
    chain[0].root <= '0;
    chain[0].rad  <= d2[RAD_W-1:0];
  end

  // square root chain, one cell per result bit
  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    cbpf_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // collector: hold one bond back so the final one can be marked
  logic             held_valid;
  logic [IDX_W-1:0] held_idx;
  logic [CUT_W-1:0] held_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      priority if (drop_go) begin
        result_valid <= 1'b1;
      end else if (chain[ROOT_W].ctl.bond) begin
        result_valid <= held_valid;
        held_valid   <= 1'b1;
      end else if (chain[ROOT_W].ctl.fin) begin
        result_valid <= held_valid;
        held_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (drop_go) begin
      earlier_index <= '0;
      new_index     <= '0;
      bond_length   <= '0;
      last_bond     <= 1'b1;
      dropped       <= 1'b1;
    end else if (chain[ROOT_W].ctl.bond || chain[ROOT_W].ctl.fin) begin
      earlier_index <= held_idx;
      new_index     <= me;
      bond_length   <= held_len;
      last_bond     <= chain[ROOT_W].ctl.fin;
      dropped       <= 1'b0;
    end
    if (chain[ROOT_W].ctl.bond) begin
      held_idx <= chain[ROOT_W].ctl.idx;
      held_len <= chain[ROOT_W].root;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    atom_count <= CNT_W'(MAX_ATOMS))
    else $error("atom count beyond store size");

  a_scan_active: assert property (@(posedge clk) disable iff (rst)
    scanning |-> active)
    else $error("scan running outside an active item");

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && dropped) |-> last_bond)
    else $error("drop beat not marked last");

  a_fresh_start: assert property (@(posedge clk) disable iff (rst)
    (accept && start_molecule) |=> (atom_count == CNT_W'(1)))
    else $error("start flag did not restart the store");

  a_bond_fin_apart: assert property (@(posedge clk) disable iff (rst)
    !(chain[ROOT_W].ctl.bond && chain[ROOT_W].ctl.fin))
    else $error("bond and end marker in one beat");

endmodule

// ----- rtl/cbpf_atom_ring.sv -----
// ----------------------------------------------------------------------------
// cbpf_atom_ring: rotating atom store
// A ring of cells; each shift moves every atom one cell toward the head.
// The head atom wraps to the tail, or is replaced by the new atom at its slot.
// ----------------------------------------------------------------------------
module cbpf_atom_ring
  import cbpf_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  logic  insert,
  input  atom_t new_atom,
  output atom_t head
);

  atom_t cells [MAX_ATOMS];

  // shift toward the head, tail takes the head or the new atom
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < MAX_ATOMS - 1; k++) begin
        cells[k] <= cells[k+1];
      end
      cells[MAX_ATOMS-1] <= insert ? new_atom : cells[0];
    end
  end

  assign head = cells[0];

endmodule

// ----- rtl/cbpf_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// cbpf_sqrt_cell: one digit of a pipelined integer square root
// Brings down two radicand bits, tries root*4+1 against the remainder and
// shifts the resulting root bit in.
// ----------------------------------------------------------------------------
module cbpf_sqrt_cell
  import cbpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sqrt_beat_t din,
  output sqrt_beat_t dout
);

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic             ge;
  logic [REM_W+1:0] diff;
  sqrt_beat_t       step_next;

  // trial subtract for this digit
  always_comb begin
    cur   = {din.rem, din.rad[RAD_W-1 -: 2]};
    trial = {2'b00, din.root, 2'b01};
    ge    = (cur >= trial);
    diff  = cur - trial;
    step_next.ctl  = din.ctl;
    step_next.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    step_next.root = {din.root[ROOT_W-2:0], ge};
    step_next.rad  = {din.rad[RAD_W-3:0], 2'b00};
  end

  // control is reset, data just follows
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctl <= '0;
    end else begin
      dout.ctl <= step_next.ctl;
    end
    dout.rem  <= step_next.rem;
    dout.root <= step_next.root;
    dout.rad  <= step_next.rad;
  end

endmodule
